>>> rtl/core/kll_pkg.sv
// kll_pkg: shared types, constants and character helpers for the keyword lexer
// used by kll_scan, kll_tok_fifo and keyword_lexer_byte_stream; no dependencies
package kll_pkg;

    // scan modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_EQ    = 3'd3;
    localparam logic [2:0] MODE_BANG  = 3'd4;

    // token kinds
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_INT     = 5'd1;
    localparam logic [4:0] KIND_KW0     = 5'd2;
    localparam logic [4:0] KIND_ASSIGN  = 5'd9;
    localparam logic [4:0] KIND_EQUAL   = 5'd10;
    localparam logic [4:0] KIND_NEQ     = 5'd11;
    localparam logic [4:0] KIND_STAR    = 5'd12;
    localparam logic [4:0] KIND_SLASH   = 5'd13;
    localparam logic [4:0] KIND_GT      = 5'd14;
    localparam logic [4:0] KIND_LT      = 5'd15;
    localparam logic [4:0] KIND_MINUS   = 5'd16;
    localparam logic [4:0] KIND_PLUS    = 5'd17;
    localparam logic [4:0] KIND_COMMA   = 5'd18;
    localparam logic [4:0] KIND_SEMI    = 5'd19;
    localparam logic [4:0] KIND_LPAREN  = 5'd20;
    localparam logic [4:0] KIND_RPAREN  = 5'd21;
    localparam logic [4:0] KIND_LBRACE  = 5'd22;
    localparam logic [4:0] KIND_RBRACE  = 5'd23;
    localparam logic [4:0] KIND_UNKNOWN = 5'd24;
    localparam logic [4:0] KIND_EOF     = 5'd25;

    localparam int          KW_NUM  = 7;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [6:0]  KW_ALL  = 7'h7F;

    // keyword lengths: fn if let true else false return
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6};

    // keyword text stored reversed so that character p sits at bits [8p +: 8]
    localparam logic [47:0] KW_TEXT_REV [KW_NUM] = '{
        48'("nf"), 48'("fi"), 48'("tel"), 48'("eurt"),
        48'("esle"), 48'("eslaf"), 48'("nruter")
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // drop keywords whose character at position idx differs from c
    function automatic logic [6:0] kw_narrow(input logic [6:0] cand, input logic [15:0] idx,
                                             input logic [7:0] c);
        logic [6:0] res;
        logic [2:0] p;
        res = cand;
        p   = idx[2:0];
        for (int i = 0; i < KW_NUM; i++) begin
            if (idx >= 16'(KW_LEN[i]) || KW_TEXT_REV[i][8*p +: 8] != c) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // identifier kind: first surviving keyword whose length matches
    function automatic logic [4:0] ident_kind(input logic [6:0] cand, input logic [15:0] len);
        logic [4:0] kind;
        logic       found;
        kind  = KIND_IDENT;
        found = 1'b0;
        for (int i = 0; i < KW_NUM; i++) begin
            if (!found && cand[i] && len == 16'(KW_LEN[i])) begin
                kind  = KIND_KW0 + 5'(i);
                found = 1'b1;
            end
        end
        return kind;
    endfunction

    // single-character punctuation
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] kind;
        case (c)
            "*": kind = KIND_STAR;
            "/": kind = KIND_SLASH;
            ">": kind = KIND_GT;
            "<": kind = KIND_LT;
            "-": kind = KIND_MINUS;
            "+": kind = KIND_PLUS;
            ",": kind = KIND_COMMA;
            ";": kind = KIND_SEMI;
            "(": kind = KIND_LPAREN;
            ")": kind = KIND_RPAREN;
            "{": kind = KIND_LBRACE;
            "}": kind = KIND_RBRACE;
            default: kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

>>> rtl/core/kll_scan.sv
// kll_scan: lexer state registers and the per-byte step logic
// produces up to two tokens per byte; depends on kll_pkg
module kll_scan #(
    parameter int MAX_TEXT = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output kll_pkg::t_token o_tok0,
    output kll_pkg::t_token o_tok1,
    output logic [1:0]      o_push_cnt
);
    import kll_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT);

    logic [2:0]       r_mode,   n_mode;
    logic [POS_W-1:0] r_pstart, n_pstart;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [6:0]       r_cand,   n_cand;
    logic [15:0]      r_plen,   n_plen;

    t_token      f_tok, e_tok;
    logic        f_vld, e_vld;
    logic [15:0] plen_inc;
    logic        cont_id, cont_int, pair;

    // continuation tests against the pending token
    assign cont_id  = (r_mode == MODE_IDENT) && (is_alpha(i_byte) || i_byte == "_");
    assign cont_int = (r_mode == MODE_INT) && is_num(i_byte);
    assign pair     = (r_mode == MODE_EQ || r_mode == MODE_BANG) && i_byte == "=";
    assign plen_inc = (r_plen == LEN_MAX) ? r_plen : r_plen + 16'd1;

    // one step of the lexer
    always_comb begin
        n_mode   = r_mode;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_cand   = r_cand;
        n_pos    = (r_pos == POS_W'(MAX_TEXT - 1)) ? '0 : r_pos + POS_W'(1);
        f_vld    = 1'b0;
        f_tok    = '0;
        e_vld    = 1'b0;
        e_tok    = '0;
        if (cont_id) begin
            n_cand = kw_narrow(r_cand, r_plen, i_byte);
            n_plen = plen_inc;
        end else if (cont_int) begin
            n_plen = plen_inc;
        end else if (pair) begin
            f_vld        = 1'b1;
            f_tok.kind   = (r_mode == MODE_EQ) ? KIND_EQUAL : KIND_NEQ;
            f_tok.start  = 16'(r_pstart);
            f_tok.length = 16'd2;
            n_mode       = MODE_IDLE;
        end else begin
            // flush the pending token
            f_tok.start = 16'(r_pstart);
            case (r_mode)
                MODE_IDENT: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = ident_kind(r_cand, r_plen);
                    f_tok.length = r_plen;
                end
                MODE_INT: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = KIND_INT;
                    f_tok.length = r_plen;
                end
                MODE_EQ: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = KIND_ASSIGN;
                    f_tok.length = 16'd1;
                end
                MODE_BANG: begin
                    f_vld        = 1'b1;
                    f_tok.kind   = KIND_UNKNOWN;
                    f_tok.length = 16'd1;
                end
                default: begin
                    f_vld = 1'b0;
                end
            endcase
            n_mode = MODE_IDLE;
            // then handle the byte as from idle
            if (i_byte == 8'h00) begin
                e_vld        = 1'b1;
                e_tok.kind   = KIND_EOF;
                e_tok.start  = 16'(r_pos);
                e_tok.length = 16'd0;
                n_pstart     = '0;
                n_plen       = 16'd0;
                n_cand       = KW_ALL;
                n_pos        = '0;
            end else if (is_ws(i_byte)) begin
                n_mode = MODE_IDLE;
            end else if (is_alpha(i_byte)) begin
                n_mode   = MODE_IDENT;
                n_pstart = r_pos;
                n_plen   = 16'd1;
                n_cand   = kw_narrow(KW_ALL, 16'd0, i_byte);
            end else if (is_num(i_byte)) begin
                n_mode   = MODE_INT;
                n_pstart = r_pos;
                n_plen   = 16'd1;
            end else if (i_byte == "=") begin
                n_mode   = MODE_EQ;
                n_pstart = r_pos;
                n_plen   = 16'd1;
            end else if (i_byte == "!") begin
                n_mode   = MODE_BANG;
                n_pstart = r_pos;
                n_plen   = 16'd1;
            end else begin
                e_vld        = 1'b1;
                e_tok.kind   = punct_kind(i_byte);
                e_tok.start  = 16'(r_pos);
                e_tok.length = 16'd1;
            end
        end
    end

    // order the results and mark the final one
    always_comb begin
        o_tok0     = f_tok;
        o_tok1     = e_tok;
        o_push_cnt = 2'd0;
        if (f_vld && e_vld) begin
            o_tok0.last = 1'b0;
            o_tok1.last = 1'b1;
            o_push_cnt  = 2'd2;
        end else if (f_vld) begin
            o_tok0.last = 1'b1;
            o_push_cnt  = 2'd1;
        end else if (e_vld) begin
            o_tok0      = e_tok;
            o_tok0.last = 1'b1;
            o_push_cnt  = 2'd1;
        end
        if (!i_step) begin
            o_push_cnt = 2'd0;
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pstart <= '0;
            r_pos    <= '0;
            r_cand   <= KW_ALL;
            r_plen   <= 16'd0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pstart <= n_pstart;
            r_pos    <= n_pos;
            r_cand   <= n_cand;
            r_plen   <= n_plen;
        end
    end

endmodule

>>> rtl/core/kll_tok_fifo.sv
// kll_tok_fifo: four-entry token queue, up to two writes and one read per cycle
// decouples the lexer step from the output channel; depends on kll_pkg
module kll_tok_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_cnt,
    input  kll_pkg::t_token i_tok0,
    input  kll_pkg::t_token i_tok1,
    output logic            o_room2,
    output logic            o_valid,
    input  logic            i_stall,
    output kll_pkg::t_token o_tok
);
    import kll_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_tok   = r_mem[r_rptr];
    // room for a two-token step after this cycle's transfer
    assign o_room2 = (r_cnt - {2'b00, pop}) <= 3'd2;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_tok1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 2'd0;
            r_rptr <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_wptr <= r_wptr + i_push_cnt;
            r_rptr <= r_rptr + {1'b0, pop};
            r_cnt  <= r_cnt + {1'b0, i_push_cnt} - {2'b00, pop};
        end
    end

endmodule

>>> rtl/core/keyword_lexer_byte_stream.sv
// keyword_lexer_byte_stream: streaming lexer top level
// holds the input byte register; uses kll_pkg, kll_scan and kll_tok_fifo
//
// One source byte per transfer on the input channel, tokens out as kind, start
// offset and length, one token per transfer on the output channel with
// o_last_of_run marking the final token a byte produced. A byte waits in the input
// register and is lexed from there, its tokens written into a four-entry token
// queue, so a byte is accepted every cycle while the queue keeps room for
// two tokens; a byte that ends a pending token and emits another puts two tokens
// out, one per output transfer. Whitespace bytes produce nothing. A zero
// byte flushes the pending token, emits eof and restarts offsets at zero.
// Offsets wrap modulo MAX_TEXT and are given as their low 16 bits.
module keyword_lexer_byte_stream #(
    parameter int MAX_TEXT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import kll_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       room2, step, take;
    logic [1:0] push_cnt;
    t_token     tok0, tok1, out_tok;

    // input register advances when its byte is lexed
    assign step       = r_in_vld && room2;
    assign take       = !r_in_vld || step;
    assign o_in_stall = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    // lexer step
    kll_scan #(
        .MAX_TEXT(MAX_TEXT)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .o_tok0     (tok0),
        .o_tok1     (tok1),
        .o_push_cnt (push_cnt)
    );

    // token queue feeding the output channel
    kll_tok_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_tok0     (tok0),
        .i_tok1     (tok1),
        .o_room2    (room2),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_tok      (out_tok)
    );

    assign o_token_kind   = out_tok.kind;
    assign o_token_start  = out_tok.start;
    assign o_token_length = out_tok.length;
    assign o_last_of_run  = out_tok.last;

endmodule

>>> tb/keyword_lexer_byte_stream_test.sv
`timescale 1ns / 1ps
// keyword_lexer_byte_stream_test: self-checking bench for the streaming keyword lexer
// drives source bytes, predicts every token and compares each output transfer
// depends on kll_pkg and keyword_lexer_byte_stream
module keyword_lexer_byte_stream_test;
    import kll_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_ITEMS  = 860;
    localparam int LONG_RUN    = 24;
    localparam int LONG_HOLD   = 200;
    localparam int IN_GAP_PCT  = 35;
    localparam int OUT_GAP_PCT = 30;
    localparam int DIR_ROWS    = 24;

    // directed row: byte, and a typed token where one is obvious
    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{"+",    1'b1, KIND_PLUS,    16'd0,  16'd1},
        '{8'hFF,  1'b1, KIND_UNKNOWN, 16'd1,  16'd1},
        '{"_",    1'b1, KIND_UNKNOWN, 16'd2,  16'd1},
        '{8'h80,  1'b1, KIND_UNKNOWN, 16'd3,  16'd1},
        '{"f",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"n",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{" ",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"!",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"x",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"!",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"=",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"=",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"=",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"=",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"9",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"0",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"a",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"_",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{8'h09,  1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{"}",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{8'h7F,  1'b1, KIND_UNKNOWN, 16'd20, 16'd1},
        '{"!",    1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{8'h00,  1'b0, KIND_IDENT,   16'd0,  16'd0},
        '{8'h00,  1'b1, KIND_EOF,     16'd0,  16'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [4:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    int          fail_count = 0;
    int          cycle_count = 0;
    int          in_gap_pct = IN_GAP_PCT;
    bit          out_hold_req = 1'b0;

    // lexer state as predicted
    logic [2:0]  lex_mode;
    logic [15:0] lex_start;
    logic [15:0] lex_pos;
    logic [15:0] lex_len;
    logic [6:0]  lex_cand;
    t_token      lex_out[$];
    t_token      tok_expect[$];
    logic [7:0]  text_q[$];

    string kw_words[KW_NUM] = '{"fn", "if", "let", "true", "else", "false", "return"};
    string punct_set = "*/><-+,;(){}";
    string op_words[7] = '{"=", "==", "!=", "!", "===", "!==", "=!"};

    keyword_lexer_byte_stream dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // character classes
    function automatic bit letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void lex_clear();
        lex_mode  = MODE_IDLE;
        lex_start = 16'd0;
        lex_pos   = 16'd0;
        lex_len   = 16'd0;
        lex_cand  = KW_ALL;
    endfunction

    // keep only keywords whose character at idx is c
    function automatic logic [6:0] kw_filter(input logic [6:0] cand, input logic [15:0] idx,
                                             input logic [7:0] c);
        logic [6:0] res;
        res = cand;
        for (int i = 0; i < KW_NUM; i++) begin
            if (res[i] && (int'(idx) >= kw_words[i].len() || kw_words[i][int'(idx)] != c)) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic void add_tok(input logic [4:0] kind, input logic [15:0] start,
                                    input logic [15:0] length);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        lex_out.push_back(t);
    endfunction

    // emit whatever token is pending and go idle
    function automatic void flush_pending();
        logic [4:0] kind;
        case (lex_mode)
            MODE_IDENT: begin
                kind = KIND_IDENT;
                for (int i = 0; i < KW_NUM; i++) begin
                    if (kind == KIND_IDENT && lex_cand[i] && int'(lex_len) == kw_words[i].len()) begin
                        kind = KIND_KW0 + 5'(i);
                    end
                end
                add_tok(kind, lex_start, lex_len);
            end
            MODE_INT:  add_tok(KIND_INT, lex_start, lex_len);
            MODE_EQ:   add_tok(KIND_ASSIGN, lex_start, 16'd1);
            MODE_BANG: add_tok(KIND_UNKNOWN, lex_start, 16'd1);
            default: begin
            end
        endcase
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void open_pending(input logic [2:0] mode, input logic [15:0] pos);
        lex_mode  = mode;
        lex_start = pos;
        lex_len   = 16'd1;
    endfunction

    // tokens caused by one byte, left in lex_out
    function automatic void lex_step(input logic [7:0] c);
        logic [15:0] pos;
        logic [4:0]  kind;
        bit          taken;
        pos   = lex_pos;
        taken = 1'b0;
        lex_out.delete();
        if (lex_mode == MODE_IDENT && (letter(c) || c == "_")) begin
            lex_cand = kw_filter(lex_cand, lex_len, c);
            if (lex_len != LEN_MAX) lex_len = lex_len + 16'd1;
            taken = 1'b1;
        end else if (lex_mode == MODE_INT && digit(c)) begin
            if (lex_len != LEN_MAX) lex_len = lex_len + 16'd1;
            taken = 1'b1;
        end else if ((lex_mode == MODE_EQ || lex_mode == MODE_BANG) && c == "=") begin
            add_tok(lex_mode == MODE_EQ ? KIND_EQUAL : KIND_NEQ, lex_start, 16'd2);
            lex_mode = MODE_IDLE;
            taken    = 1'b1;
        end else begin
            flush_pending();
        end
        // offsets wrap at 16 bits, matching the default text size
        lex_pos = pos + 16'd1;
        if (!taken) begin
            if (c == 8'h00) begin
                add_tok(KIND_EOF, pos, 16'd0);
                lex_clear();
            end else if (blank(c)) begin
                // whitespace only moves the offset
            end else if (letter(c)) begin
                open_pending(MODE_IDENT, pos);
                lex_cand = kw_filter(KW_ALL, 16'd0, c);
            end else if (digit(c)) begin
                open_pending(MODE_INT, pos);
            end else if (c == "=") begin
                open_pending(MODE_EQ, pos);
            end else if (c == "!") begin
                open_pending(MODE_BANG, pos);
            end else begin
                kind = KIND_UNKNOWN;
                for (int p = 0; p < punct_set.len(); p++) begin
                    if (punct_set[p] == c) kind = KIND_STAR + 5'(p);
                end
                add_tok(kind, pos, 16'd1);
            end
        end
        if (lex_out.size() > 0) lex_out[lex_out.size() - 1].last = 1'b1;
    endfunction

    // gap lengths: mostly none or short, a few long
    function automatic int pick_gap(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // one input transfer, then its tokens go on the expected list
    task automatic push_byte(input logic [7:0] b, input bit typed, input t_token want);
        int gap;
        gap = pick_gap(in_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lex_step(b);
        if (typed) begin
            want.last = 1'b1;
            tok_expect.push_back(want);
        end else begin
            foreach (lex_out[k]) tok_expect.push_back(lex_out[k]);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tok_expect.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        int v;
        v = $urandom_range(0, 51);
        return v < 26 ? 8'(8'h61 + v) : 8'(8'h41 + v - 26);
    endfunction

    function automatic logic [7:0] rand_ident_char();
        return ($urandom_range(0, 4) == 0) ? 8'h5F : rand_letter();
    endfunction

    function automatic void put_str(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endfunction

    // one lexeme of random text, mostly well formed, with an optional separator
    function automatic void gen_piece();
        string w;
        int    r;
        int    j;
        r = $urandom_range(0, 99);
        w = kw_words[$urandom_range(0, KW_NUM - 1)];
        if (r < 22) begin
            put_str(w);
        end else if (r < 32) begin
            // near misses of a keyword
            case ($urandom_range(0, 2))
                0: begin
                    put_str(w);
                    text_q.push_back(rand_ident_char());
                end
                1: put_str(w.substr(0, w.len() - 2));
                default: begin
                    j = $urandom_range(0, w.len() - 1);
                    for (int k = 0; k < w.len(); k++) begin
                        text_q.push_back(k == j ? 8'(w[k] - 8'd32) : w[k]);
                    end
                end
            endcase
        end else if (r < 48) begin
            text_q.push_back(rand_letter());
            repeat ($urandom_range(0, 8)) text_q.push_back(rand_ident_char());
        end else if (r < 60) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end else if (r < 72) begin
            put_str(op_words[$urandom_range(0, 6)]);
        end else if (r < 86) begin
            text_q.push_back(punct_set[$urandom_range(0, 11)]);
        end else if (r < 96) begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            text_q.push_back(8'h00);
        end
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 2)) begin
                j = $urandom_range(0, 5);
                text_q.push_back(j == 0 ? 8'h20 : 8'(8 + j));
            end
        end
    endfunction

    // long identifier or integer sent at full input rate
    task automatic long_run(input logic [7:0] lead, input bit letters);
        t_token none;
        none = '0;
        push_byte(lead, 1'b0, none);
        repeat (LONG_RUN) begin
            push_byte(letters ? rand_ident_char() : 8'(8'h30 + $urandom_range(0, 9)),
                      1'b0, none);
        end
        push_byte(8'h20, 1'b0, none);
    endtask

    // receiver stalls: random gaps, calm stretches, one long hold on request
    initial begin : out_side
        int stall_left;
        int calm_left;
        int hold_left;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (out_hold_req) begin
                out_hold_req = 1'b0;
                hold_left    = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 4) begin
                calm_left = $urandom_range(30, 120);
                i_out_stall <= 1'b0;
            end else begin
                stall_left = pick_gap(OUT_GAP_PCT);
                i_out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    function automatic void field_check(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // compare each output transfer with the oldest expected token
    always @(posedge i_clk) begin : tok_check
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tok_expect.size() == 0) begin
                $display("%0t: token kind %0d start %0d length %0d with nothing expected",
                         $time, o_token_kind, o_token_start, o_token_length);
                fail_count++;
            end else begin
                want = tok_expect.pop_front();
                field_check("token_kind", 16'(want.kind), 16'(o_token_kind));
                field_check("token_start", want.start, o_token_start);
                field_check("token_length", want.length, o_token_length);
                field_check("last_of_run", 16'(want.last), 16'(o_last_of_run));
            end
        end
    end

    // stimulus
    initial begin : in_side
        t_token want;
        int     sent;
        lex_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            want.kind   = DIR_TAB[r].kind;
            want.start  = DIR_TAB[r].start;
            want.length = DIR_TAB[r].length;
            want.last   = 1'b1;
            push_byte(DIR_TAB[r].b, DIR_TAB[r].typed, want);
        end

        // long tokens, sender at full rate
        in_gap_pct = 0;
        long_run("f", 1'b1);
        long_run("7", 1'b0);

        // random text
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 100 == 0) in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : IN_GAP_PCT;
            if (sent == 300) begin
                // receiver holds off while bytes keep coming
                in_gap_pct   = 0;
                out_hold_req = 1'b1;
            end
            if (sent == 600) wait_drained();
            if (text_q.size() == 0) gen_piece();
            want = '0;
            push_byte(text_q.pop_front(), 1'b0, want);
            sent++;
        end
        while (text_q.size() != 0) begin
            want = '0;
            push_byte(text_q.pop_front(), 1'b0, want);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
